>>> design/cpu_bus_memory_io_responder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bus memory and I/O responder.
// Defining ASSERT_OFF removes every assertion from the build.
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_MEMORY_IO_RESPONDER_MACROS_SVH
`define CPU_BUS_MEMORY_IO_RESPONDER_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define CBMIO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define CBMIO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define CBMIO_ASSERT_NOW(label, clk, rst, ante, cons)
`define CBMIO_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/cbmio_pkg.sv
// ----------------------------------------------------------------------------
// cbmio_pkg
// Types, address map, port codes and program image shared by the responder.
// ----------------------------------------------------------------------------
package cbmio_pkg;

   // Address map of memory space.
   localparam int ROM_BYTES = 14336;
   localparam int RAM_BYTES = 2048;
   localparam int RAM_BASE  = 14336;

   localparam int ADDR_W = 14;
   localparam int RAM_AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;

   // Limits held one bit wider than the address so that the top of the map fits.
   localparam logic [ADDR_W:0] ROM_LIMIT = (ADDR_W + 1)'(ROM_BYTES);
   localparam logic [ADDR_W:0] RAM_LO    = (ADDR_W + 1)'(RAM_BASE);
   localparam logic [ADDR_W:0] RAM_HI    = (ADDR_W + 1)'(RAM_BASE + RAM_BYTES);

   // I/O port codes, decoded from the low address byte.
   localparam logic [7:0] PORT_SERIAL_DATA   = 8'hE0;
   localparam logic [7:0] PORT_SERIAL_STATUS = 8'hE1;
   localparam logic [7:0] PORT_LAMP_BUTTON   = 8'hD0;
   localparam logic [7:0] EMPTY_READ         = 8'hFF;

   // Program image; ROM addresses past its end read zero.
   localparam int IMAGE_LEN = 60;
   localparam int IMAGE_AW  = $clog2(IMAGE_LEN);

   localparam logic [7:0] PROGRAM_IMAGE [0:IMAGE_LEN-1] = '{
      8'h31, 8'h00, 8'h40, 8'h21, 8'h2d, 8'h00, 8'h7e, 8'hfe,
      8'h00, 8'h28, 8'h06, 8'hcd, 8'h19, 8'h00, 8'h23, 8'h18,
      8'hf5, 8'hcd, 8'h24, 8'h00, 8'hcd, 8'h19, 8'h00, 8'h18,
      8'hf8, 8'hf5, 8'hdb, 8'he1, 8'hcb, 8'h4f, 8'h28, 8'hfa,
      8'hf1, 8'hd3, 8'he0, 8'hc9, 8'hdb, 8'he1, 8'hcb, 8'h47,
      8'h28, 8'hfa, 8'hdb, 8'he0, 8'hc9, 8'h48, 8'h45, 8'h4c,
      8'h4c, 8'h4f, 8'h2c, 8'h20, 8'h57, 8'h4f, 8'h52, 8'h4c,
      8'h44, 8'h0d, 8'h0a, 8'h00
   };

   // One bus access.
   typedef struct packed {
      logic              access_is_write;
      logic              access_is_io;
      logic [ADDR_W-1:0] bus_address;
      logic [7:0]        write_byte;
      logic              rx_ready;
      logic [7:0]        rx_byte;
      logic              tx_ready;
      logic              button_level;
   } req_type;

   // One response to a bus access.
   typedef struct packed {
      logic [7:0] read_byte;
      logic       tx_strobe;
      logic [7:0] tx_byte;
      logic       lamp_level;
   } rsp_type;

   // Byte of the program store at a ROM address.
   function automatic logic [7:0] rom_byte(input logic [ADDR_W-1:0] addr);
      logic [7:0] value;
      value = 8'h00;
      if (addr < ADDR_W'(IMAGE_LEN)) begin
         value = PROGRAM_IMAGE[addr[IMAGE_AW-1:0]];
      end
      return value;
   endfunction

endpackage

>>> design/cbmio_ram.sv
// ----------------------------------------------------------------------------
// cbmio_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module cbmio_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                      wdata,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   // Write, or read with the data registered, at the enabled address.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/cpu_bus_memory_io_responder.sv
// ----------------------------------------------------------------------------
// cpu_bus_memory_io_responder
// Answers 8-bit processor bus accesses to ROM, RAM and three I/O ports.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on req_payload at a rising edge where start is high
//   and busy is low. Its response appears on rsp_payload with rsp_strobe high
//   for exactly one cycle, the cycle after the transaction was taken.
//   Once busy is low, a new transaction can be taken every cycle: the RAM is
//   written at the accepting edge and read through its registered port in
//   the following cycle, so a read straight after a write to the same
//   address already sees the new byte.
//   Memory reads below ROM_BYTES come from the program image, reads in the RAM
//   window from the work RAM, all other memory reads give 0xFF. I/O accesses
//   decode the low address byte only: serial data, serial status and the
//   lamp/button port. rsp_payload.lamp_level shows the lamp after the access.
//   Reset clears the lamp and the response strobe and sets busy, which drops
//   again once reset is released; the work RAM is not cleared and must be
//   written before it is read. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
`include "cpu_bus_memory_io_responder_macros.svh"

module cpu_bus_memory_io_responder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cbmio_pkg::req_type req_payload,
   output logic               rsp_strobe,
   output cbmio_pkg::rsp_type rsp_payload
);

   import cbmio_pkg::*;

   logic              accept;
   logic [7:0]        port;
   logic              is_rom;
   logic              is_ram;
   logic [RAM_AW-1:0] ram_offset;
   logic              ram_we;
   logic              ram_read_in;
   logic [7:0]        ram_rdata;
   logic              lamp_write;
   logic [7:0]        io_rdata;

   logic       busy_ff,    busy_in;
   logic       valid_ff,   valid_in;
   logic       use_ram_ff, use_ram_in;
   logic [7:0] byte_ff,    byte_in;
   logic       strobe_ff,  strobe_in;
   logic [7:0] tx_ff,      tx_in;
   logic       lamp_ff,    lamp_in;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // Address decode of the transaction.
   assign port       = req_payload.bus_address[7:0];
   assign is_rom     = {1'b0, req_payload.bus_address} < ROM_LIMIT;
   assign is_ram     = ({1'b0, req_payload.bus_address} >= RAM_LO) &&
                       ({1'b0, req_payload.bus_address} < RAM_HI);
   assign ram_offset = RAM_AW'(req_payload.bus_address - ADDR_W'(RAM_BASE));

   // RAM accesses: writes land in the window, reads only where ROM does not win.
   assign ram_we      = accept && req_payload.access_is_write &&
                        !req_payload.access_is_io && is_ram;
   assign ram_read_in = !req_payload.access_is_write && !req_payload.access_is_io &&
                        !is_rom && is_ram;
   assign lamp_write  = req_payload.access_is_write && req_payload.access_is_io &&
                        (port == PORT_LAMP_BUTTON);

   cbmio_ram #(
      .WIDTH (8),
      .DEPTH (RAM_BYTES)
   ) u_work_ram (
      .clock (clock),
      .en    (ram_we || (accept && ram_read_in)),
      .we    (ram_we),
      .addr  (ram_offset),
      .wdata (req_payload.write_byte),
      .rdata (ram_rdata)
   );

   // I/O read decode.
   always_comb begin
      unique case (port)
         PORT_SERIAL_DATA:   io_rdata = req_payload.rx_byte;
         PORT_SERIAL_STATUS: io_rdata = {6'b0, req_payload.tx_ready, req_payload.rx_ready};
         PORT_LAMP_BUTTON:   io_rdata = {7'b0, req_payload.button_level};
         default:            io_rdata = EMPTY_READ;
      endcase
   end

   // Response stage and lamp next values.
   always_comb begin
      busy_in    = 1'b0;
      valid_in   = accept;
      use_ram_in = ram_read_in;
      byte_in    = 8'h00;
      strobe_in  = 1'b0;
      tx_in      = 8'h00;
      lamp_in    = lamp_ff;
      if (req_payload.access_is_write) begin
         if (req_payload.access_is_io && (port == PORT_SERIAL_DATA)) begin
            strobe_in = 1'b1;
            tx_in     = req_payload.write_byte;
         end
      end else if (req_payload.access_is_io) begin
         byte_in = io_rdata;
      end else if (is_rom) begin
         byte_in = rom_byte(req_payload.bus_address);
      end else if (!is_ram) begin
         byte_in = EMPTY_READ;
      end
      if (accept && lamp_write) begin
         lamp_in = req_payload.write_byte[0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
         lamp_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         lamp_ff  <= lamp_in;
      end
   end

   // Payload registers of the response stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         use_ram_ff <= use_ram_in;
         byte_ff    <= byte_in;
         strobe_ff  <= strobe_in;
         tx_ff      <= tx_in;
      end
   end

   // Response ports.
   assign rsp_strobe             = valid_ff;
   assign rsp_payload.read_byte  = use_ram_ff ? ram_rdata : byte_ff;
   assign rsp_payload.tx_strobe  = strobe_ff;
   assign rsp_payload.tx_byte    = tx_ff;
   assign rsp_payload.lamp_level = lamp_ff;

   // Every accepted transaction gives one response in the next cycle, and no other.
   `CBMIO_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_strobe)
   `CBMIO_ASSERT_NEXT(a_no_rsp_without_accept, clock, reset, !accept, !rsp_strobe)
   // The lamp only changes through an accepted write to its port.
   `CBMIO_ASSERT_NEXT(a_lamp_holds, clock, reset, !(accept && lamp_write), $stable(lamp_ff))
   // A RAM read response never carries a transmit strobe.
   `CBMIO_ASSERT_NOW(a_ram_read_no_tx, clock, reset, rsp_strobe && use_ram_ff, !strobe_ff)

endmodule
